/* rtl/swfp_pkg.sv */
// ----------------------------------------------------------------------------
// swfp_pkg
// Shared constants and types for the scale weight frame parser: the frame
// characters, the frame kinds and the result carried to the output register.
// ----------------------------------------------------------------------------
package swfp_pkg;

  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned WeightW  = 17;
  localparam int unsigned PartialW = 14;
  localparam int unsigned PosW     = 3;

  localparam logic [PosW-1:0] POS_WAIT  = 3'd0;
  localparam logic [PosW-1:0] POS_FIRST = 3'd1;
  localparam logic [PosW-1:0] POS_LAST  = 3'd5;
  localparam logic [PosW-1:0] POS_ETX   = 3'd6;

  localparam logic [WeightW-1:0] TenThousand = 17'd10000;

  typedef enum logic [1:0] {
    KIND_WEIGHT    = 2'd0,
    KIND_STATUS    = 2'd1,
    KIND_NEGATIVE  = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [WeightW-1:0]  weight;
    logic                stable;
  } result_t;

endpackage

/* rtl/swfp_rx_if.sv */
// ----------------------------------------------------------------------------
// swfp_rx_if
// Received byte channel: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
interface swfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/swfp_res_if.sv */
// ----------------------------------------------------------------------------
// swfp_res_if
// Frame result channel: valid/ready handshake with kind, weight and stable.
// ----------------------------------------------------------------------------
interface swfp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_kind;
  logic [16:0] weight_value;
  logic        is_stable;

  modport source (output valid, output frame_kind, output weight_value,
                  output is_stable, input ready);
  modport sink   (input valid, input frame_kind, input weight_value,
                  input is_stable, output ready);
endinterface

/* rtl/swfp_frame_track.sv */
// ----------------------------------------------------------------------------
// swfp_frame_track
// Frame state tracker: follows byte position, collects the first character,
// letter and digit checks and the partial weight, and judges the frame on
// its seventh byte, updating the held weight and stable mark.
// ----------------------------------------------------------------------------
module swfp_frame_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output swfp_pkg::result_t res_o
);

  logic [swfp_pkg::PosW-1:0]     pos_q, pos_d;
  logic [7:0]                    first_q, first_d;
  logic                          match_q, match_d;
  logic                          dvalid_q, dvalid_d;
  logic [swfp_pkg::PartialW-1:0] part_q, part_d;
  logic [swfp_pkg::WeightW-1:0]  held_w_q, held_w_d;
  logic                          held_s_q, held_s_d;

  logic                          byte_digit;
  logic                          first_digit;
  logic                          first_letter;
  logic [3:0]                    byte_val;
  logic [3:0]                    first_val;
  logic [swfp_pkg::PartialW-1:0] part_acc;
  logic [swfp_pkg::WeightW-1:0]  new_weight;
  swfp_pkg::kind_e               kind;

  assign byte_digit   = (byte_i >= swfp_pkg::CH_ZERO) && (byte_i <= swfp_pkg::CH_NINE);
  assign first_digit  = (first_q >= swfp_pkg::CH_ZERO) && (first_q <= swfp_pkg::CH_NINE);
  assign first_letter = (first_q == swfp_pkg::CH_I) || (first_q == swfp_pkg::CH_N) ||
                        (first_q == swfp_pkg::CH_S);
  assign byte_val     = 4'(byte_i - swfp_pkg::CH_ZERO);
  assign first_val    = 4'(first_q - swfp_pkg::CH_ZERO);
  // times ten as shift and add
  assign part_acc     = swfp_pkg::PartialW'({part_q, 3'b000}) +
                        swfp_pkg::PartialW'({part_q, 1'b0}) +
                        swfp_pkg::PartialW'(byte_val);

  // judgement of a complete frame
  always_comb begin
    kind       = swfp_pkg::KIND_MALFORMED;
    new_weight = swfp_pkg::WeightW'(part_q);
    priority if (byte_i != swfp_pkg::CH_ETX) begin
      kind = swfp_pkg::KIND_MALFORMED;
    end else if (first_letter) begin
      kind = match_q ? swfp_pkg::KIND_STATUS : swfp_pkg::KIND_MALFORMED;
    end else if (!dvalid_q) begin
      kind = swfp_pkg::KIND_MALFORMED;
    end else if (first_q == swfp_pkg::CH_MINUS) begin
      kind = swfp_pkg::KIND_NEGATIVE;
    end else if (first_q == swfp_pkg::CH_SPACE) begin
      kind = swfp_pkg::KIND_WEIGHT;
    end else if (first_digit) begin
      kind       = swfp_pkg::KIND_WEIGHT;
      new_weight = swfp_pkg::WeightW'(first_val * swfp_pkg::TenThousand) +
                   swfp_pkg::WeightW'(part_q);
    end else begin
      kind = swfp_pkg::KIND_MALFORMED;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    first_d     = first_q;
    match_d     = match_q;
    dvalid_d    = dvalid_q;
    part_d      = part_q;
    held_w_d    = held_w_q;
    held_s_d    = held_s_q;
    res_valid_o = 1'b0;
    if (step_i) begin
      priority if (pos_q == swfp_pkg::POS_WAIT || pos_q > swfp_pkg::POS_ETX) begin
        first_d  = '0;
        match_d  = 1'b1;
        dvalid_d = 1'b1;
        part_d   = '0;
        pos_d    = (byte_i == swfp_pkg::CH_STX) ? swfp_pkg::POS_FIRST : swfp_pkg::POS_WAIT;
      end else if (pos_q == swfp_pkg::POS_FIRST) begin
        first_d = byte_i;
        pos_d   = pos_q + 3'd1;
      end else if (pos_q <= swfp_pkg::POS_LAST) begin
        if (byte_i != first_q) begin
          match_d = 1'b0;
        end
        if (byte_digit) begin
          part_d = part_acc;
        end else begin
          dvalid_d = 1'b0;
        end
        pos_d = pos_q + 3'd1;
      end else begin
        res_valid_o = 1'b1;
        unique case (kind)
          swfp_pkg::KIND_WEIGHT: begin
            held_w_d = new_weight;
            held_s_d = (new_weight != '0);
          end
          swfp_pkg::KIND_STATUS,
          swfp_pkg::KIND_NEGATIVE: begin
            held_s_d = 1'b0;
          end
          default: begin
          end
        endcase
        first_d  = '0;
        match_d  = 1'b1;
        dvalid_d = 1'b1;
        part_d   = '0;
        pos_d    = swfp_pkg::POS_WAIT;
      end
    end
  end

  assign res_o.kind   = kind;
  assign res_o.weight = held_w_d;
  assign res_o.stable = held_s_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= swfp_pkg::POS_WAIT;
      first_q  <= '0;
      match_q  <= 1'b1;
      dvalid_q <= 1'b1;
      part_q   <= '0;
      held_w_q <= '0;
      held_s_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      first_q  <= first_d;
      match_q  <= match_d;
      dvalid_q <= dvalid_d;
      part_q   <= part_d;
      held_w_q <= held_w_d;
      held_s_q <= held_s_d;
    end
  end

endmodule

/* rtl/swfp_res_reg.sv */
// ----------------------------------------------------------------------------
// swfp_res_reg
// Result register: holds one frame result until the sink takes the result
// and reports when it can load a new one.
// ----------------------------------------------------------------------------
module swfp_res_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  swfp_pkg::result_t res_i,
  output logic              free_o,
  swfp_res_if.source        res_o
);

  logic              valid_q, valid_d;
  swfp_pkg::result_t data_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = load_i ? 1'b1 : (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.frame_kind   = data_q.kind;
  assign res_o.weight_value = data_q.weight;
  assign res_o.is_stable    = data_q.stable;

endmodule

/* rtl/scale_weight_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// scale_weight_frame_parser_unit
// Timing: a closing byte is registered in the input register, and its result then in the result register.
// Throughput: one byte per cycle; bytes stall while a result waits unread.
// Bytes that close no frame give no result.
// Reset: asynchronous, clears the frame state, held weight and stable mark,
// and empties the input and result registers.
// ----------------------------------------------------------------------------
module scale_weight_frame_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  swfp_rx_if.sink    rx_i,
  swfp_res_if.source res_o
);

  logic              in_valid_q, in_valid_d;
  logic [7:0]        in_byte_q;
  logic              out_free;
  logic              step;
  logic              res_valid;
  swfp_pkg::result_t res;

  // a request moves on when the result register can take it
  assign step       = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || out_free;
  assign in_valid_d = rx_i.ready ? rx_i.valid : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  swfp_frame_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  swfp_res_reg u_res (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && res_valid),
    .res_i  (res),
    .free_o (out_free),
    .res_o  (res_o)
  );

endmodule
